FILE: hdl/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// fcsg_pkg: shared types and constants of the filled circle span generator
// Holds the coordinate widths, the transaction payloads, the register indexes
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fcsg_pkg;

	localparam int COORD_BITS = 12;
	localparam int RAD_BITS   = 5;
	localparam int MAX_RADIUS = 31;
	localparam int CFG_BITS   = 13;
	localparam int COORD_SPAN = 1 << COORD_BITS;

	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET  = 13'd640;
	localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [COORD_BITS-1:0] center_x;
		logic [COORD_BITS-1:0] center_y;
		logic [RAD_BITS-1:0]   radius;
	} circle_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] row_y;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] x_end;
		logic                  visible;
		logic                  last_span;
	} span_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_SEARCH,
		ST_LOWER,
		ST_UPPER
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new circle
		logic emit;      // write a span into the output register
		logic upper;     // the span lies above the center row
		logic last;      // the span closes the circle
		logic dec_half;  // narrow the half-width by one column
		logic inc_d;     // move to the next vertical offset
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register can take a span this cycle
		logic shrink;    // the current half-width is still too wide
		logic r_zero;    // the circle has zero radius
		logic d_last;    // the offset has reached the radius
	} status_t;

endpackage

FILE: hdl/filled_circle_span_generator.sv
// ----------------------------------------------------------------------------
// filled_circle_span_generator: one clipped horizontal span per circle row
// The center span is written into the output register once the circle is
// accepted and the register has room, and is then offered on the output.
// The half-width search removes one column per cycle, r columns in all,
// and each offset ends its search before its lower and upper rows; a new
// circle is taken only after the closing span of the last one is written.
// Reset: asynchronous, active low; clears the sequencer and the output valid,
// and sets the image size to 640 by 480.
// ----------------------------------------------------------------------------
module filled_circle_span_generator
	import fcsg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    circle_valid,
	output logic                    circle_stall,
	input  circle_t                 circle,
	output logic                    span_valid,
	input  logic                    span_stall,
	output span_t                   span,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	// The controller walks the rows of a circle: the center row first, then
	// for each vertical offset a search that narrows the half-width, followed
	// by the row below and the row above the center. The datapath owns every
	// register that holds a value and reports back only what the controller
	// needs to branch on.
	cmd_t    cmd;
	status_t st;

	// Register writes are taken at any time and none is held off; the user is
	// to change the image size only between circles, which is not enforced.
	assign cfg_ready = 1'b1;

	fcsg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.circle_valid (circle_valid),
		.circle_stall (circle_stall),
		.st           (st),
		.cmd          (cmd)
	);

	// The output register in the datapath decouples the span channel, so a
	// new circle can be accepted while the final span still waits.
	fcsg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.circle     (circle),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.st         (st),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span)
	);

	// A span is only written when the output register has room for it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("span written while the output register was full");

	// An accepted circle keeps the input channel stalled until it is done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(circle_valid && !circle_stall) |=> circle_stall)
		else $error("input not stalled after a circle transaction");

	// Writing the closing span frees the input channel in the next cycle.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> !circle_stall)
		else $error("input still stalled after the closing span");

	// The search never narrows below zero columns.
	a_shrink_positive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_half |-> (st.shrink && !cmd.emit))
		else $error("half-width decremented without a failed fit");

endmodule

FILE: hdl/fcsg_ctrl.sv
// ----------------------------------------------------------------------------
// fcsg_ctrl: sequencer of the filled circle span generator
// Steps through the center row, the half-width search and the lower and
// upper rows of each vertical offset.
// ----------------------------------------------------------------------------
module fcsg_ctrl
	import fcsg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    circle_valid,
	output logic    circle_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		circle_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (circle_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CENTER;
				end
			end
			ST_CENTER: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					cmd.last  = st.r_zero;
					cmd.inc_d = !st.r_zero;
					state_d   = st.r_zero ? ST_IDLE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (st.shrink) begin
					cmd.dec_half = 1'b1;
				end else begin
					state_d = ST_LOWER;
				end
			end
			ST_LOWER: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_UPPER;
				end
			end
			ST_UPPER: begin
				if (st.out_free) begin
					cmd.emit  = 1'b1;
					cmd.upper = 1'b1;
					cmd.last  = st.d_last;
					cmd.inc_d = !st.d_last;
					state_d   = st.d_last ? ST_IDLE : ST_SEARCH;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/fcsg_dp.sv
// ----------------------------------------------------------------------------
// fcsg_dp: datapath of the filled circle span generator
// Holds the image size registers, the circle under work, the half-width and
// offset counters, the span clipping logic and the output register.
// ----------------------------------------------------------------------------
module fcsg_dp
	import fcsg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  circle_t                 circle,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  cmd_t                    cmd,
	output status_t                 st,
	output logic                    span_valid,
	input  logic                    span_stall,
	output span_t                   span
);

	localparam int CB  = COORD_BITS;
	localparam int SQB = 2 * RAD_BITS;

	logic [CFG_BITS-1:0] width_q, height_q;
	logic [CB-1:0]       cx_q, cy_q;
	logic [RAD_BITS-1:0] r_q, half_q, d_q;
	logic                span_valid_q;
	span_t               span_q;

	logic [RAD_BITS-1:0] r_sat;
	logic [SQB-1:0]      half_sq, d_sq, r_sq;
	logic [SQB:0]        sum_sq;
	logic [CB:0]         w_eff, h_eff, hi_raw, hi_clip;
	logic signed [CB+1:0] row_s, lo_raw, cx_ext, cy_ext, d_ext, half_ext;
	logic [CB-1:0]       lo_clip;
	logic                vis;
	span_t               span_new;

	assign r_sat = (circle.radius > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
	                                                      : circle.radius;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RESET;
			height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q   <= circle.center_x;
			cy_q   <= circle.center_y;
			r_q    <= r_sat;
			half_q <= r_sat;
			d_q    <= '0;
		end else begin
			if (cmd.dec_half) begin
				half_q <= half_q - 1'b1;
			end
			if (cmd.inc_d) begin
				d_q <= d_q + 1'b1;
			end
		end
	end

	// Half-width test: the current width is too wide while h*h + d*d > r*r.
	always_comb begin
		half_sq = {{RAD_BITS{1'b0}}, half_q} * {{RAD_BITS{1'b0}}, half_q};
		d_sq    = {{RAD_BITS{1'b0}}, d_q} * {{RAD_BITS{1'b0}}, d_q};
		r_sq    = {{RAD_BITS{1'b0}}, r_q} * {{RAD_BITS{1'b0}}, r_q};
		sum_sq  = {1'b0, half_sq} + {1'b0, d_sq};
	end

	assign st.shrink   = (half_q != '0) && (sum_sq > {1'b0, r_sq});
	assign st.r_zero   = (r_q == '0);
	assign st.d_last   = (d_q == r_q);
	assign st.out_free = !span_valid_q || !span_stall;

	// Span clipping against the image.
	always_comb begin
		w_eff = (width_q > CFG_BITS'(COORD_SPAN)) ? (CB+1)'(COORD_SPAN)
		                                         : (CB+1)'(width_q);
		h_eff = (height_q > CFG_BITS'(COORD_SPAN)) ? (CB+1)'(COORD_SPAN)
		                                          : (CB+1)'(height_q);
		cx_ext   = $signed({2'b00, cx_q});
		cy_ext   = $signed({2'b00, cy_q});
		d_ext    = $signed({{(CB+2-RAD_BITS){1'b0}}, d_q});
		half_ext = $signed({{(CB+2-RAD_BITS){1'b0}}, half_q});
		row_s    = cmd.upper ? (cy_ext - d_ext) : (cy_ext + d_ext);
		lo_raw   = cx_ext - half_ext;
		hi_raw   = {1'b0, cx_q} + {{(CB+1-RAD_BITS){1'b0}}, half_q};
		hi_clip  = (hi_raw >= w_eff) ? (w_eff - 1'b1) : hi_raw;
		lo_clip  = lo_raw[CB+1] ? '0 : lo_raw[CB-1:0];
		vis = !row_s[CB+1] && (row_s < $signed({1'b0, h_eff})) && (w_eff != '0)
		      && (lo_raw < $signed({1'b0, w_eff}));
		span_new.row_y     = vis ? row_s[CB-1:0] : '0;
		span_new.x_start   = vis ? lo_clip : '0;
		span_new.x_end     = vis ? hi_clip[CB-1:0] : '0;
		span_new.visible   = vis;
		span_new.last_span = cmd.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			span_valid_q <= 1'b1;
		end else if (!span_stall) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			span_q <= span_new;
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

endmodule
